### src/cppt_pkg.sv
// ----------------------------------------------------------------------------
// cppt_pkg
// Shared types and codes for the content peer page table: request and
// response words, operation and status codes, controller states, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cppt_pkg;

   // Operation codes carried in the request word
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_INIT   = 2'd3
   } op_type;

   // Status codes carried in the response word
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_WRONG_PAGE = 2'd1;
   localparam logic [1:0] STAT_PAGE_EMPTY = 2'd2;

   // Request word
   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] cont_id;
      logic [31:0] content_type;
      logic [7:0]  revision;
      logic [31:0] peer_id;
   } req_type;

   // Response word
   typedef struct packed {
      logic [1:0]  status;
      logic        removed_mark;
      logic [1:0]  peer_count;
      logic [31:0] found_peer_0;
      logic [31:0] found_peer_1;
      logic [31:0] found_peer_2;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_LOOK,
      ST_EXEC
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_wr;   // write one zero row of the clearing sweep
      logic capture;  // take the request word, start the index unit
      logic look;     // read the entry, check the page
      logic init;     // set tag and type, empty the page, answer
      logic exec;     // apply the operation to the entry, answer
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic mod_done;  // entry index is ready
      logic clr_last;  // sweep is at its last row
      logic is_init;   // captured request is an initialize
   } stat_type;

endpackage

### src/cppt_ram.sv
// ----------------------------------------------------------------------------
// cppt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cppt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/cppt_mod.sv
// ----------------------------------------------------------------------------
// cppt_mod
// Entry index unit: cont_id mod ENTRIES. A power-of-two page registers the
// low bits; any other page size runs a long-division residue, four bits of
// the id per cycle.
// ----------------------------------------------------------------------------
module cppt_mod #(
   parameter int ENTRIES = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [63:0]                cont_id,
   output logic [$clog2(ENTRIES)-1:0] idx,
   output logic                       done
);

   localparam int  IDX_W = $clog2(ENTRIES);
   localparam bit  POW2  = (ENTRIES & (ENTRIES - 1)) == 0;

   generate
      if (POW2) begin : g_pow2
         logic [IDX_W-1:0] idx_ff;
         logic             done_ff;

         // Take the low bits
         always_ff @(posedge clock) begin
            if (load) begin
               idx_ff <= cont_id[IDX_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= load;
            end
         end

         assign idx  = idx_ff;
         assign done = done_ff;
      end else begin : g_div
         localparam int DIGIT = 4;
         localparam int STEPS = 64 / DIGIT;
         localparam int CNT_W = $clog2(STEPS);
         localparam int RW    = IDX_W + 1;

         logic [RW-1:0]    rem_ff,  rem_in;
         logic [63:0]      sh_ff,   sh_in;
         logic [CNT_W-1:0] cnt_ff;
         logic             run_ff;
         logic             done_ff;

         // Shift in one digit, reduce after every bit
         always_comb begin
            rem_in = rem_ff;
            sh_in  = sh_ff;
            for (int i = 0; i < DIGIT; i++) begin
               rem_in = {rem_in[RW-2:0], sh_in[63]};
               sh_in  = {sh_in[62:0], 1'b0};
               if (rem_in >= RW'(ENTRIES)) begin
                  rem_in = rem_in - RW'(ENTRIES);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (load) begin
               rem_ff <= '0;
               sh_ff  <= cont_id;
            end else if (run_ff) begin
               rem_ff <= rem_in;
               sh_ff  <= sh_in;
            end
         end

         // Step counter and completion pulse
         always_ff @(posedge clock) begin
            if (reset) begin
               cnt_ff  <= '0;
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               done_ff <= 1'b0;
               if (load) begin
                  cnt_ff <= '0;
                  run_ff <= 1'b1;
               end else if (run_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == CNT_W'(STEPS - 1)) begin
                     run_ff  <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end

         assign idx  = rem_ff[IDX_W-1:0];
         assign done = done_ff;
      end
   endgenerate

endmodule

### src/cppt_dp.sv
// ----------------------------------------------------------------------------
// cppt_dp
// Datapath: request register, index unit, entry RAM, page tag, type and
// live count, clearing sweep address, and the per-entry update logic.
// ----------------------------------------------------------------------------
module cppt_dp #(
   parameter int ENTRIES   = 256,
   parameter int PEER_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  cppt_pkg::req_type  req_word,
   input  cppt_pkg::cmd_type  cmd,
   output cppt_pkg::stat_type stat,
   output logic               rsp_strobe,
   output cppt_pkg::rsp_type  rsp_word
);

   import cppt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int LC_W  = $clog2(ENTRIES + 1);
   localparam int PB    = PEER_BITS;
   localparam int ROW_W = 9 + 3 * PB;

   req_type          req_ff;
   logic [IDX_W-1:0] idx;
   logic             mod_done;
   logic [63:0]      tag_ff,  tag_in;
   logic [31:0]      type_ff;
   logic [LC_W-1:0]  live_ff, live_in;
   logic [IDX_W-1:0] clr_cnt_ff;
   logic             page_ok_ff;
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] new_row;
   logic             row_wr;
   logic             ram_wr;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic [63:0]      pid_wide;
   logic [PB-1:0]    peer;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff,  rsp_in;

   // Hold the request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
   end

   cppt_mod #(
      .ENTRIES (ENTRIES)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .load    (cmd.capture),
      .cont_id (req_word.cont_id),
      .idx     (idx),
      .done    (mod_done)
   );

   // Page base of the request
   assign tag_in = req_ff.cont_id - 64'(idx);

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         page_ok_ff <= (tag_in == tag_ff) && (req_ff.content_type == type_ff);
      end
   end

   // Entry RAM: clearing sweep or update write
   assign ram_wr      = cmd.clr_wr || row_wr;
   assign ram_wr_addr = cmd.clr_wr ? clr_cnt_ff : idx;
   assign ram_wr_data = cmd.clr_wr ? '0 : new_row;

   cppt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.look),
      .rd_addr (idx),
      .rd_data (rd_row)
   );

   // Peer handle at storage width
   assign pid_wide = {32'b0, req_ff.peer_id};
   assign peer     = pid_wide[PB-1:0];

   // Apply the operation to the entry
   always_comb begin
      logic [7:0]    rev_st;
      logic          rmk;
      logic [PB-1:0] s [3];
      logic [PB-1:0] t [3];
      logic          old_ne;
      logic          new_ne;
      logic          hit;
      logic          rev_eq;
      logic [1:0]    n;
      logic [63:0]   w0, w1, w2;

      rev_st = rd_row[7:0];
      rmk    = rd_row[8];
      for (int k = 0; k < 3; k++) begin
         s[k] = rd_row[9 + k * PB +: PB];
         t[k] = s[k];
      end
      old_ne = (s[0] != '0) || (s[1] != '0) || (s[2] != '0);
      rev_eq = rev_st == req_ff.revision;
      hit    = 1'b0;
      n      = 2'd3;
      w0     = 64'(s[0]);
      w1     = 64'(s[1]);
      w2     = 64'(s[2]);
      rsp_in = '0;
      row_wr = 1'b0;
      live_in = live_ff;

      unique case (req_ff.operation)
         OP_INSERT: begin
            // Drop a stale entry, then add the peer
            if (!rev_eq && old_ne) begin
               t[0] = '0;
               t[1] = '0;
               t[2] = '0;
               rmk  = 1'b0;
            end
            if (peer != '0) begin
               if (t[0] == '0 || t[0] == peer) begin
                  t[0] = peer;
               end else if (t[1] == '0 || t[1] == peer) begin
                  t[1] = peer;
               end else if (t[2] == '0 || t[2] == peer) begin
                  t[2] = peer;
               end else begin
                  t[0] = peer;
               end
            end
            rev_st = req_ff.revision;
         end
         OP_FIND: begin
            // Return peers up to the first empty slot
            if (rmk) begin
               rsp_in.removed_mark = 1'b1;
            end else if (rev_eq) begin
               if (s[0] == '0) begin
                  n = 2'd0;
               end else if (s[1] == '0) begin
                  n = 2'd1;
               end else if (s[2] == '0) begin
                  n = 2'd2;
               end
               rsp_in.peer_count   = n;
               rsp_in.found_peer_0 = (n > 2'd0) ? w0[31:0] : 32'b0;
               rsp_in.found_peer_1 = (n > 2'd1) ? w1[31:0] : 32'b0;
               rsp_in.found_peer_2 = (n > 2'd2) ? w2[31:0] : 32'b0;
            end
         end
         OP_REMOVE: begin
            // Shift the slots down over the matching one
            if (rev_eq) begin
               if (s[0] == peer) begin
                  hit  = 1'b1;
                  t[0] = s[1];
                  t[1] = s[2];
               end else if (s[1] == peer) begin
                  hit  = 1'b1;
                  t[1] = s[2];
               end else if (s[2] == peer) begin
                  hit  = 1'b1;
               end
               if (hit) begin
                  t[2] = '0;
               end
            end
         end
         default: begin
         end
      endcase

      new_ne = (t[0] != '0) || (t[1] != '0) || (t[2] != '0);
      if (req_ff.operation == OP_REMOVE && hit && !new_ne) begin
         rmk = 1'b1;
      end
      new_row = {t[2], t[1], t[0], rmk, rev_st};

      if (req_ff.operation == OP_INSERT || req_ff.operation == OP_REMOVE) begin
         row_wr = cmd.exec && page_ok_ff;
      end

      // Track live entries
      if (page_ok_ff) begin
         if (new_ne && !old_ne) begin
            live_in = live_ff + 1'b1;
         end else if (old_ne && !new_ne) begin
            live_in = live_ff - 1'b1;
            if (req_ff.operation == OP_REMOVE && live_ff == LC_W'(1)) begin
               rsp_in.status = STAT_PAGE_EMPTY;
            end
         end
      end

      if (!page_ok_ff) begin
         rsp_in        = '0;
         rsp_in.status = STAT_WRONG_PAGE;
      end
      if (cmd.init) begin
         rsp_in = '0;
      end
   end

   // Page tag, type and live count
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= '0;
         type_ff <= '0;
         live_ff <= '0;
      end else if (cmd.init) begin
         tag_ff  <= tag_in;
         type_ff <= req_ff.content_type;
         live_ff <= '0;
      end else if (cmd.exec) begin
         live_ff <= live_in;
      end
   end

   // Advance the clearing sweep, wrap at the last row
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         if (clr_cnt_ff == IDX_W'(ENTRIES - 1)) begin
            clr_cnt_ff <= '0;
         end else begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   // Register the response word and its strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.exec || cmd.init;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec || cmd.init) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_word      = rsp_ff;
   assign stat.mod_done = mod_done;
   assign stat.clr_last = clr_cnt_ff == IDX_W'(ENTRIES - 1);
   assign stat.is_init  = req_ff.operation == OP_INIT;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd.exec || cmd.init))
      else $error("response word without an exec or init command");

   a_live_range: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> live_ff <= LC_W'(ENTRIES))
      else $error("live count beyond page size");

   a_init_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.init |=> (live_ff == '0 && clr_cnt_ff == '0))
      else $error("initialize did not empty the page");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> !row_wr)
      else $error("entry update during clearing sweep");

endmodule

### src/cppt_ctrl.sv
// ----------------------------------------------------------------------------
// cppt_ctrl
// Controller: sequences clearing, request capture, index computation,
// entry read and entry update.
// ----------------------------------------------------------------------------
module cppt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cppt_pkg::stat_type stat,
   output cppt_pkg::cmd_type  cmd
);

   import cppt_pkg::*;

   state_type state_ff, state_in;

   // State register; reset starts with a clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_MOD;
            end
         end
         ST_MOD: begin
            if (stat.mod_done) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            if (stat.is_init) begin
               cmd.init = 1'b1;
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_wr, cmd.capture, cmd.exec}))
      else $error("conflicting datapath commands");

   a_capture_then_mod: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_MOD)
      else $error("capture not followed by index computation");

   a_exec_after_look: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> $past(cmd.look) && !$past(stat.is_init))
      else $error("exec without an entry read");

endmodule

### src/content_peer_page_table.sv
// ----------------------------------------------------------------------------
// content_peer_page_table
// One page of content entries with revision, three peer slots and a
// removed mark per entry, plus page tag, type and live entry count.
// ----------------------------------------------------------------------------
// A request word is taken at a clock edge with start high and busy low; its
// single response word appears later for exactly one cycle with rsp_strobe
// high, and must be taken then, since the receiver cannot hold it off. Busy
// is high after accept until the response. With ENTRIES a power of two
// the entry index is the low id bits; any other ENTRIES uses a residue
// computation of the index, four id bits per cycle. The entry RAM is read
// in the look state and, for an insert or remove, written back in the exec
// state that follows. After reset, and after every initialize, a clearing
// pass writes zero to all ENTRIES rows, one per cycle, busy high throughout.
// ----------------------------------------------------------------------------
module content_peer_page_table #(
   parameter int ENTRIES   = 256,
   parameter int PEER_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cppt_pkg::req_type req_word,
   output logic              rsp_strobe,
   output cppt_pkg::rsp_type rsp_word
);

   import cppt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cppt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cppt_dp #(
      .ENTRIES   (ENTRIES),
      .PEER_BITS (PEER_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule
